// File: hdl/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // stream widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned LenW   = 64;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned HcntW  = 4;
  localparam int unsigned MposW  = 2;
  localparam int unsigned Len7W  = 7;
  localparam int unsigned OpW    = 4;

  // header field codes
  localparam int unsigned        FinBit       = 7;
  localparam logic [OpW-1:0]     OpcodeMask   = 4'hF;
  localparam logic [OpW-1:0]     OpcodeClose  = 4'h8;
  localparam logic [Len7W-1:0]   LenExt16     = 7'd126;
  localparam logic [Len7W-1:0]   LenExt64     = 7'd127;
  localparam logic [HcntW-1:0]   Ext16Bytes   = 4'd2;
  localparam logic [HcntW-1:0]   Ext64Bytes   = 4'd8;
  localparam logic [HcntW-1:0]   MaskBytes    = 4'd4;

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  // result kind
  typedef enum logic [KindW-1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOM   = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  // one result item plus its presence flag
  typedef struct packed {
    logic             vld;
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/wsd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       step_i,  // consume byte_i this cycle
  input  wire  [wsd_pkg::ByteW-1:0] byte_i,
  output wsd_pkg::res_t             res_o    // result for byte_i, valid with step_i
);
  import wsd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [HcntW-1:0] hcnt_q, hcnt_d;
  logic             fin_q, fin_d;
  logic             close_q, close_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [MposW-1:0] mpos_q, mpos_d;

  logic [Len7W-1:0] len7;
  logic [HcntW-1:0] hcnt_dec;
  logic [LenW-1:0]  rem_dec;
  logic             rem_one;
  logic [ByteW-1:0] key_byte;

  assign len7     = byte_i[Len7W-1:0];
  assign hcnt_dec = hcnt_q - HcntW'(1);
  assign rem_dec  = rem_q - LenW'(1);
  assign rem_one  = (rem_q == LenW'(1));

  // mask byte for the current payload position, first key byte in the top bits
  always_comb begin
    case (mpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state and result for one byte
  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    fin_d   = fin_q;
    close_d = close_q;
    rem_d   = rem_q;
    key_d   = key_q;
    mpos_d  = mpos_q;
    res_o   = '{vld: 1'b0, kind: KIND_DATA, data: '0, last: 1'b0};

    case (phase_q)
      PH_HDR1: begin
        rem_d = '0;
        if (len7 == LenExt16) begin
          hcnt_d  = Ext16Bytes;
          phase_d = PH_EXT;
        end else if (len7 == LenExt64) begin
          hcnt_d  = Ext64Bytes;
          phase_d = PH_EXT;
        end else begin
          rem_d   = LenW'(len7);
          hcnt_d  = MaskBytes;
          phase_d = PH_MASK;
        end
        if (close_q) begin
          res_o = '{vld: 1'b1, kind: KIND_CLOSE, data: '0, last: 1'b0};
        end
      end

      PH_EXT: begin
        rem_d  = {rem_q[LenW-ByteW-1:0], byte_i};
        hcnt_d = hcnt_dec;
        if (hcnt_dec == '0) begin
          hcnt_d  = MaskBytes;
          phase_d = PH_MASK;
        end
      end

      PH_MASK: begin
        key_d  = {key_q[KeyW-ByteW-1:0], byte_i};
        hcnt_d = hcnt_dec;
        if (hcnt_dec == '0) begin
          mpos_d = '0;
          if (rem_q == '0) begin
            phase_d = PH_HDR0;
            // empty final frame closes the message with a bare marker
            if (fin_q && !close_q) begin
              res_o = '{vld: 1'b1, kind: KIND_EOM, data: '0, last: 1'b1};
            end
          end else begin
            phase_d = PH_DATA;
          end
        end
      end

      PH_DATA: begin
        mpos_d = mpos_q + MposW'(1);
        rem_d  = rem_dec;
        if (rem_one) begin
          phase_d = PH_HDR0;
        end
        // close frame payload is swallowed
        if (!close_q) begin
          res_o = '{vld: 1'b1, kind: KIND_DATA, data: byte_i ^ key_byte,
                    last: fin_q && rem_one};
        end
      end

      default: begin
        fin_d   = byte_i[FinBit];
        close_d = ((byte_i[OpW-1:0] & OpcodeMask) == OpcodeClose);
        hcnt_d  = '0;
        phase_d = PH_HDR1;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      hcnt_q  <= '0;
      fin_q   <= 1'b0;
      close_q <= 1'b0;
      rem_q   <= '0;
      key_q   <= '0;
      mpos_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      fin_q   <= fin_d;
      close_q <= close_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      mpos_q  <= mpos_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata[7:0] in_byte
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata[7:0] data_byte, tuser[1:0] kind,
//                                                    tlast last_of_message
//
// one byte per clock unless a result stalls at the output; results come from the result register
// each byte passes an input register and the parser logic; a result then a result register
// a byte that gives no result never waits on the output side
// reset clears the parser to expect the first header byte of a new frame
// input ready falls only while a result waits and the next byte would give another

module websocket_frame_deframer_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [wsd_pkg::ByteW-1:0]       s_axis_tdata,   // [7:0] in_byte
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [wsd_pkg::ByteW-1:0]       m_axis_tdata,   // [7:0] data_byte
  output logic [wsd_pkg::KindW-1:0]       m_axis_tuser,   // [1:0] kind
  output logic                            m_axis_tlast    // last_of_message
);
  import wsd_pkg::*;

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  res_t             out_q;
  res_t             res;
  logic             s_accept;
  logic             fire;

  // parse one byte when its result, if any, has room
  assign fire          = in_vld_q && (!res.vld || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // valid flags for input and result stages
  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire && res.vld) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
    end
    if (fire && res.vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// File: hdl/wsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [wsd_pkg::ByteW-1:0]   m_axis_tdata,
  input wire [wsd_pkg::KindW-1:0]   m_axis_tuser,
  input wire                        m_axis_tlast
);
  import wsd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // only the three defined kinds appear
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_EOM
                       || m_axis_tuser == KIND_CLOSE))
    else $error("undefined result kind");

  // markers carry no byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata == '0)
    else $error("marker with non-zero data");

  // close result never ends a message
  a_close_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_CLOSE |-> !m_axis_tlast)
    else $error("close result marked last");

  // bare end marker always ends a message
  a_eom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_EOM |-> m_axis_tlast)
    else $error("end marker not marked last");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
